[rtl/core/polycv_pkg.sv]
// Shared types and constants for the polygon convexity checker.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package polycv_pkg;

    // Coordinate and normal width (two's complement, Q16.16 at 32 bits)
    localparam int COORD_WIDTH = 32;

    // Edge vector component: difference of two coordinates
    localparam int DIFF_W  = COORD_WIDTH + 1;
    // Cross product component: difference of two DIFF_W x DIFF_W products
    localparam int CROSS_W = 2 * DIFF_W + 1;
    // Cross product is split into a low unsigned part and a high signed part
    localparam int LO_W    = DIFF_W + 1;
    localparam int HI_W    = CROSS_W - LO_W;
    // Shared multiplier operand and product widths
    localparam int MUL_A_W = LO_W + 1;
    localparam int MUL_B_W = DIFF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // Dot product accumulator: three CROSS_W x COORD_WIDTH terms, exact
    localparam int DOT_W   = CROSS_W + COORD_WIDTH + 2;

    // Multiplier steps per triple: six for the cross product, six for the dot
    localparam int MUL_STEPS = 12;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Stream payload widths
    localparam int IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_Z = 2'd2;

    // Job kinds
    localparam logic [1:0] JOB_CHECK     = 2'd0;  // test one triple
    localparam logic [1:0] JOB_CHECK_END = 2'd1;  // test last triple, emit result
    localparam logic [1:0] JOB_FEW       = 2'd2;  // short polygon, emit result

    // One triple as its edge vectors a = p - o and b = q - p
    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] ay;
        logic signed [DIFF_W-1:0] az;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] bz;
    } job_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/core/polycv_front.sv]
// Front end: takes vertex beats, tracks the vertex window of the polygon
// and turns each triple into an edge-vector job. Depends on polycv_pkg.
`timescale 1ns / 1ps

module polycv_front
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] vx,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] vy,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] vz,
    input  logic                                     in_last,
    input  polycv_pkg::queue_status_t                q_status,
    output logic                                     push,
    output polycv_pkg::job_t                         push_job
);

    // Wrap-around sequencer codes
    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_WRAP1 = 2'd1;
    localparam logic [1:0] W_WRAP2 = 2'd2;

    logic signed [polycv_pkg::COORD_WIDTH-1:0] first_x_reg, first_y_reg, first_z_reg;
    logic signed [polycv_pkg::COORD_WIDTH-1:0] second_x_reg, second_y_reg, second_z_reg;
    logic signed [polycv_pkg::COORD_WIDTH-1:0] older_x_reg, older_y_reg, older_z_reg;
    logic signed [polycv_pkg::COORD_WIDTH-1:0] newer_x_reg, newer_y_reg, newer_z_reg;
    // vertices seen: 0, 1, or 2 meaning two or more
    logic [1:0] seen_reg, seen_next;
    logic [1:0] wrap_reg, wrap_next;
    logic       accept;

    // Build a job from three points o, p, q
    function automatic polycv_pkg::job_t make_job(
        input logic signed [polycv_pkg::COORD_WIDTH-1:0] ox, oy, oz,
        input logic signed [polycv_pkg::COORD_WIDTH-1:0] px, py, pz,
        input logic signed [polycv_pkg::COORD_WIDTH-1:0] qx, qy, qz,
        input logic [1:0] kind
    );
        polycv_pkg::job_t j;
        j.kind = kind;
        j.ax = polycv_pkg::DIFF_W'(px) - polycv_pkg::DIFF_W'(ox);
        j.ay = polycv_pkg::DIFF_W'(py) - polycv_pkg::DIFF_W'(oy);
        j.az = polycv_pkg::DIFF_W'(pz) - polycv_pkg::DIFF_W'(oz);
        j.bx = polycv_pkg::DIFF_W'(qx) - polycv_pkg::DIFF_W'(px);
        j.by = polycv_pkg::DIFF_W'(qy) - polycv_pkg::DIFF_W'(py);
        j.bz = polycv_pkg::DIFF_W'(qz) - polycv_pkg::DIFF_W'(pz);
        return j;
    endfunction

    assign in_ready = (wrap_reg == W_IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;

    // Job generation and window sequencing
    always_comb
    begin
        push      = 1'b0;
        push_job  = '0;
        wrap_next = wrap_reg;
        seen_next = seen_reg;
        case (wrap_reg)
            W_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg == 2'd2)
                    begin
                        push     = 1'b1;
                        push_job = make_job(older_x_reg, older_y_reg, older_z_reg,
                                            newer_x_reg, newer_y_reg, newer_z_reg,
                                            vx, vy, vz, polycv_pkg::JOB_CHECK);
                    end
                    else if (in_last)
                    begin
                        push          = 1'b1;
                        push_job      = '0;
                        push_job.kind = polycv_pkg::JOB_FEW;
                    end
                    if (in_last)
                    begin
                        seen_next = 2'd0;
                    end
                    else if (seen_reg != 2'd2)
                    begin
                        seen_next = seen_reg + 2'd1;
                    end
                    if (in_last && seen_reg == 2'd2)
                    begin
                        wrap_next = W_WRAP1;
                    end
                end
            end
            W_WRAP1:
            begin
                // triple (v[n-2], v[n-1], v[0])
                if (!q_status.full)
                begin
                    push      = 1'b1;
                    push_job  = make_job(older_x_reg, older_y_reg, older_z_reg,
                                         newer_x_reg, newer_y_reg, newer_z_reg,
                                         first_x_reg, first_y_reg, first_z_reg,
                                         polycv_pkg::JOB_CHECK);
                    wrap_next = W_WRAP2;
                end
            end
            W_WRAP2:
            begin
                // triple (v[n-1], v[0], v[1]) closes the polygon
                if (!q_status.full)
                begin
                    push      = 1'b1;
                    push_job  = make_job(newer_x_reg, newer_y_reg, newer_z_reg,
                                         first_x_reg, first_y_reg, first_z_reg,
                                         second_x_reg, second_y_reg, second_z_reg,
                                         polycv_pkg::JOB_CHECK_END);
                    wrap_next = W_IDLE;
                end
            end
            default:
            begin
                wrap_next = W_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 2'd0;
            wrap_reg <= W_IDLE;
        end
        else
        begin
            seen_reg <= seen_next;
            wrap_reg <= wrap_next;
        end
    end

    // Vertex window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (seen_reg == 2'd0)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
                first_z_reg <= vz;
            end
            if (seen_reg == 2'd1)
            begin
                second_x_reg <= vx;
                second_y_reg <= vy;
                second_z_reg <= vz;
            end
            older_x_reg <= newer_x_reg;
            older_y_reg <= newer_y_reg;
            older_z_reg <= newer_z_reg;
            newer_x_reg <= vx;
            newer_y_reg <= vy;
            newer_z_reg <= vz;
        end
    end

endmodule

[rtl/core/polycv_queue.sv]
// Short job queue between the front end and the sign unit.
// Register file with head/tail pointers. Depends on polycv_pkg.
`timescale 1ns / 1ps

module polycv_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  polycv_pkg::job_t          push_job,
    input  logic                      pop,
    output polycv_pkg::job_t          head_job,
    output polycv_pkg::queue_status_t status
);

    polycv_pkg::job_t              entry_reg [polycv_pkg::QUEUE_DEPTH];
    logic [polycv_pkg::QPTR_W-1:0] head_reg, tail_reg;
    logic [polycv_pkg::QPTR_W:0]   count_reg;
    logic                          do_push, do_pop;

    assign status.full  = (count_reg == (polycv_pkg::QPTR_W + 1)'(polycv_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[head_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (do_pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_job;
        end
    end

endmodule

[rtl/core/polycv_back.sv]
// Sign unit: evaluates ((p-o) x (q-p)) . n exactly on one shared multiplier,
// folds the signs of a polygon and holds the result beat. Depends on polycv_pkg.
`timescale 1ns / 1ps

module polycv_back
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  polycv_pkg::queue_status_t                 q_status,
    input  polycv_pkg::job_t                          q_job,
    output logic                                      pop,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] normal_x,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] normal_y,
    input  logic signed [polycv_pkg::COORD_WIDTH-1:0] normal_z,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic                                      out_convex,
    output logic                                      out_few
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int A_W = polycv_pkg::MUL_A_W;
    localparam int B_W = polycv_pkg::MUL_B_W;
    localparam int C_W = polycv_pkg::CROSS_W;
    localparam int D_W = polycv_pkg::DOT_W;
    localparam int L_W = polycv_pkg::LO_W;

    logic [1:0]                         state_reg, state_next;
    logic [polycv_pkg::STEP_W-1:0]      step_reg, step_next, prev_step;
    logic [1:0]                         kind_reg;
    logic signed [polycv_pkg::DIFF_W-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [polycv_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [A_W-1:0]              mul_a;
    logic signed [B_W-1:0]              mul_b;
    logic signed [C_W-1:0]              cx_reg, cy_reg, cz_reg;
    logic signed [C_W-1:0]              cx_next, cy_next, cz_next;
    logic signed [D_W-1:0]              d_reg, d_next;
    logic                               convex_reg, convex_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_convex_reg, out_convex_next;
    logic                               out_few_reg, out_few_next;
    logic                               negative, need_out, fin_go;

    // Split a cross component into high signed and low unsigned operands
    function automatic logic signed [A_W-1:0] hi_part(input logic signed [C_W-1:0] c);
        return A_W'($signed(c[C_W-1:L_W]));
    endfunction

    function automatic logic signed [A_W-1:0] lo_part(input logic signed [C_W-1:0] c);
        return $signed({1'b0, c[L_W-1:0]});
    endfunction

    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign prev_step = step_reg - 1'b1;
    assign negative  = d_reg[D_W-1];
    assign need_out  = (kind_reg != polycv_pkg::JOB_CHECK);
    assign fin_go    = !need_out || !out_valid_reg || out_ready;

    // Multiplier operand schedule: cross terms, then dot terms
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:  begin mul_a = A_W'(ay_reg); mul_b = bz_reg; end
            4'd1:  begin mul_a = A_W'(az_reg); mul_b = by_reg; end
            4'd2:  begin mul_a = A_W'(az_reg); mul_b = bx_reg; end
            4'd3:  begin mul_a = A_W'(ax_reg); mul_b = bz_reg; end
            4'd4:  begin mul_a = A_W'(ax_reg); mul_b = by_reg; end
            4'd5:  begin mul_a = A_W'(ay_reg); mul_b = bx_reg; end
            4'd6:  begin mul_a = hi_part(cx_reg); mul_b = B_W'(normal_x); end
            4'd7:  begin mul_a = lo_part(cx_reg); mul_b = B_W'(normal_x); end
            4'd8:  begin mul_a = hi_part(cy_reg); mul_b = B_W'(normal_y); end
            4'd9:  begin mul_a = lo_part(cy_reg); mul_b = B_W'(normal_y); end
            4'd10: begin mul_a = hi_part(cz_reg); mul_b = B_W'(normal_z); end
            4'd11: begin mul_a = lo_part(cz_reg); mul_b = B_W'(normal_z); end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Sequencer, accumulation of the previous product, result handling
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        d_next          = d_reg;
        convex_next     = convex_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_convex_next = out_convex_reg;
        out_few_next    = out_few_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cx_next   = '0;
                    cy_next   = '0;
                    cz_next   = '0;
                    d_next    = '0;
                    step_next = '0;
                    state_next = (q_job.kind == polycv_pkg::JOB_FEW) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg != '0)
                begin
                    case (prev_step)
                        4'd0:  cx_next = cx_reg + C_W'(prod_reg);
                        4'd1:  cx_next = cx_reg - C_W'(prod_reg);
                        4'd2:  cy_next = cy_reg + C_W'(prod_reg);
                        4'd3:  cy_next = cy_reg - C_W'(prod_reg);
                        4'd4:  cz_next = cz_reg + C_W'(prod_reg);
                        4'd5:  cz_next = cz_reg - C_W'(prod_reg);
                        4'd6, 4'd8, 4'd10:
                            d_next = d_reg + (D_W'(prod_reg) <<< L_W);
                        4'd7, 4'd9, 4'd11:
                            d_next = d_reg + D_W'(prod_reg);
                        default:
                            d_next = d_reg;
                    endcase
                end
                if (step_reg == polycv_pkg::STEP_W'(polycv_pkg::MUL_STEPS))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                    case (kind_reg)
                        polycv_pkg::JOB_CHECK:
                        begin
                            convex_next = convex_reg && !negative;
                        end
                        polycv_pkg::JOB_CHECK_END:
                        begin
                            out_valid_next  = 1'b1;
                            out_convex_next = convex_reg && !negative;
                            out_few_next    = 1'b0;
                            convex_next     = 1'b1;
                        end
                        default:
                        begin
                            // short polygon
                            out_valid_next  = 1'b1;
                            out_convex_next = 1'b1;
                            out_few_next    = 1'b1;
                            convex_next     = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            convex_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            convex_reg    <= convex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= q_job.kind;
            ax_reg   <= q_job.ax;
            ay_reg   <= q_job.ay;
            az_reg   <= q_job.az;
            bx_reg   <= q_job.bx;
            by_reg   <= q_job.by;
            bz_reg   <= q_job.bz;
        end
        prod_reg       <= prod_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        d_reg          <= d_next;
        out_convex_reg <= out_convex_next;
        out_few_reg    <= out_few_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_convex = out_convex_reg;
    assign out_few    = out_few_reg;

endmodule

[rtl/core/polygon_convexity_check.sv]
// Polygon convexity checker. Vertices arrive one beat each (x, y, z as signed
// Q16.16 in tdata, tlast on the final vertex); the plane normal is set through
// the configuration port, by the user only while the block is idle; the block
// itself does not enforce this. One result beat per polygon carries is_convex
// and too_few_vertices. Each vertex from the third on, and the two wrap-around
// triples at the end, cost one sign evaluation on the shared 35x33 multiplier
// (12 multiply steps plus load, drain and fold). A 4-entry job queue lets the
// vertex side run ahead of the sign unit, and the result sits in an output
// register so the next polygon can start while it waits. No clearing pass.
// Depends on polycv_pkg, polycv_front, polycv_queue and polycv_back.
`timescale 1ns / 1ps

module polygon_convexity_check
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // vertex stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [polycv_pkg::IN_DATA_W-1:0]       s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                                   s_tlast,   // last_vertex
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [polycv_pkg::OUT_DATA_W-1:0]      m_tdata,   // is_convex, too_few_vertices, zeros
    // configuration
    input  logic                                   cfg_we,
    input  logic [polycv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [polycv_pkg::COORD_WIDTH-1:0]     cfg_wdata
);

    localparam int CW = polycv_pkg::COORD_WIDTH;

    logic signed [CW-1:0]      normal_x_reg, normal_y_reg, normal_z_reg;
    logic                      push, pop;
    polycv_pkg::job_t          push_job, head_job;
    polycv_pkg::queue_status_t q_status;
    logic                      out_convex, out_few;

    // Plane normal registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                polycv_pkg::CFG_NORMAL_X: normal_x_reg <= $signed(cfg_wdata);
                polycv_pkg::CFG_NORMAL_Y: normal_y_reg <= $signed(cfg_wdata);
                polycv_pkg::CFG_NORMAL_Z: normal_z_reg <= $signed(cfg_wdata);
                default:
                begin
                    normal_x_reg <= normal_x_reg;
                end
            endcase
        end
    end

    // Front end
    polycv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .vx       ($signed(s_tdata[CW-1:0])),
        .vy       ($signed(s_tdata[2*CW-1:CW])),
        .vz       ($signed(s_tdata[3*CW-1:2*CW])),
        .in_last  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Job queue
    polycv_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Sign unit and result register
    polycv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_job      (head_job),
        .pop        (pop),
        .normal_x   (normal_x_reg),
        .normal_y   (normal_y_reg),
        .normal_z   (normal_z_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_convex (out_convex),
        .out_few    (out_few)
    );

    assign m_tdata = {(polycv_pkg::OUT_DATA_W - 2)'(0), out_few, out_convex};

endmodule

[rtl/core/polycv_checker.sv]
// Port-level checks for polygon_convexity_check, attached by bind.
// Depends on polycv_pkg.
`timescale 1ns / 1ps

module polycv_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [polycv_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // Held result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Held result beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A short polygon is always reported convex
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("too_few_vertices without is_convex");

    // No result can appear the cycle after reset release without a prior vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind polygon_convexity_check polycv_checker u_polycv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_polygon_convexity_check.sv]
// Self-checking testbench for polygon_convexity_check: streams polygons (directed
// corners, then random convex outlines and noise) and checks every verdict.
// Depends on polycv_pkg and the polygon_convexity_check RTL only.
`timescale 1ns / 1ps

module tb_polygon_convexity_check;

    localparam int SETTLE_CYCLES = 40;    // sign unit drain after the last verdict
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int STALL_LIMIT   = 5000;  // cycles without any beat or register write
    localparam int CHUNK_ITEMS   = 60;    // vertices per normal setting
    localparam int PHASE_ITEMS   = 430;

    localparam logic signed [polycv_pkg::COORD_WIDTH-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [polycv_pkg::COORD_WIDTH-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [polycv_pkg::COORD_WIDTH-1:0] C_ONE = 32'sh0001_0000;

    typedef logic signed [polycv_pkg::COORD_WIDTH-1:0] coord_t;
    typedef logic signed [127:0]                       wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        logic is_convex;
        logic too_few;
    } verdict_t;

    typedef enum {PLAN_WRITE, PLAN_VERTEX} plan_kind_e;

    typedef struct {
        plan_kind_e                          kind;
        logic [polycv_pkg::CFG_INDEX_W-1:0]  reg_index;
        coord_t                              value;
        vertex_t                             vtx;
        bit                                  last;
        bit                                  typed;
        verdict_t                            want;
    } plan_row_t;

    // DUT ports
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [polycv_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic                                s_tlast = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [polycv_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                                cfg_we = 1'b0;
    logic [polycv_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [polycv_pkg::COORD_WIDTH-1:0]  cfg_wdata = '0;

    // Predictor copy of the block's configuration and window
    coord_t      normal_x = '0;
    coord_t      normal_y = '0;
    coord_t      normal_z = '0;
    vertex_t     first_vtx, second_vtx, older_vtx, newer_vtx;
    int unsigned vertices_in_poly = 0;
    bit          convex_so_far = 1'b1;

    verdict_t    pending_verdicts[$];
    plan_row_t   directed_plan[$];
    vertex_t     outline[$];
    int          plane_axis = 2;

    // Run control and statistics
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requested = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int verdicts_checked = 0;
    int convex_seen = 0;
    int short_seen = 0;
    int normal_writes = 0;
    verdict_t got_verdict, want_verdict;

    // Convex 12-gon in counter-clockwise order, scaled per outline
    int ring_u[12] = '{10, 9, 5, 0, -5, -9, -10, -9, -5, 0, 5, 9};
    int ring_v[12] = '{0, 5, 9, 10, 9, 5, 0, -5, -9, -10, -9, -5};

    polygon_convexity_check uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // vertex_x, vertex_y, vertex_z
        .s_tlast   (s_tlast),   // last_vertex
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // is_convex, too_few_vertices, zeros
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // True when ((p - o) x (q - p)) . normal is negative, exact at 128 bits
    function automatic bit turn_is_negative(input vertex_t o, input vertex_t p,
                                            input vertex_t q);
        wide_t ax, ay, az, bx, by, bz, cx, cy, cz, dot;
        ax = wide_t'($signed(p.x)) - wide_t'($signed(o.x));
        ay = wide_t'($signed(p.y)) - wide_t'($signed(o.y));
        az = wide_t'($signed(p.z)) - wide_t'($signed(o.z));
        bx = wide_t'($signed(q.x)) - wide_t'($signed(p.x));
        by = wide_t'($signed(q.y)) - wide_t'($signed(p.y));
        bz = wide_t'($signed(q.z)) - wide_t'($signed(p.z));
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        dot = cx * wide_t'($signed(normal_x)) + cy * wide_t'($signed(normal_y))
            + cz * wide_t'($signed(normal_z));
        return dot[127];
    endfunction

    // Advance the convexity window by one vertex; returns 1 when a verdict is due
    function automatic bit advance_convexity(input vertex_t v, input bit last,
                                             output verdict_t verdict);
        verdict = '0;
        if (vertices_in_poly == 0)
            first_vtx = v;
        else if (vertices_in_poly == 1)
            second_vtx = v;
        else if (turn_is_negative(older_vtx, newer_vtx, v))
            convex_so_far = 1'b0;
        if (vertices_in_poly < 3)
            vertices_in_poly++;
        older_vtx = newer_vtx;
        newer_vtx = v;
        if (!last)
            return 1'b0;
        if (vertices_in_poly < 3)
        begin
            verdict.is_convex = 1'b1;
            verdict.too_few   = 1'b1;
        end
        else
        begin
            // wrap-around triples
            if (turn_is_negative(older_vtx, newer_vtx, first_vtx))
                convex_so_far = 1'b0;
            if (turn_is_negative(newer_vtx, first_vtx, second_vtx))
                convex_so_far = 1'b0;
            verdict.is_convex = convex_so_far;
            verdict.too_few   = 1'b0;
        end
        vertices_in_poly = 0;
        convex_so_far = 1'b1;
        return 1'b1;
    endfunction

    function automatic vertex_t make_vertex(input coord_t x, input coord_t y, input coord_t z);
        vertex_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    // Place (u, v) in the plane normal to plane_axis, cyclic so +axis sees CCW
    function automatic vertex_t on_plane(input int u, input int v, input int w);
        case (plane_axis)
            0:       return make_vertex(coord_t'(w), coord_t'(u), coord_t'(v));
            1:       return make_vertex(coord_t'(v), coord_t'(w), coord_t'(u));
            default: return make_vertex(coord_t'(u), coord_t'(v), coord_t'(w));
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        return make_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endfunction

    // Directed table builders
    task automatic add_plan_row(input plan_row_t r);
        directed_plan.insert(directed_plan.size(), r);
    endtask

    task automatic plan_write(input logic [polycv_pkg::CFG_INDEX_W-1:0] idx,
                              input coord_t val);
        plan_row_t r;
        r = '{kind: PLAN_WRITE, reg_index: idx, value: val, vtx: '0, last: 1'b0,
              typed: 1'b0, want: '0};
        add_plan_row(r);
    endtask

    task automatic plan_vertex(input coord_t x, input coord_t y, input coord_t z,
                               input bit last);
        plan_row_t r;
        r = '{kind: PLAN_VERTEX, reg_index: '0, value: '0, vtx: make_vertex(x, y, z),
              last: last, typed: 1'b0, want: '0};
        add_plan_row(r);
    endtask

    task automatic plan_checked(input coord_t x, input coord_t y, input coord_t z,
                                input bit conv, input bit few);
        plan_row_t r;
        r = '{kind: PLAN_VERTEX, reg_index: '0, value: '0, vtx: make_vertex(x, y, z),
              last: 1'b1, typed: 1'b1, want: '{is_convex: conv, too_few: few}};
        add_plan_row(r);
    endtask

    task automatic build_directed_plan();
        // single vertex and two-vertex polygons right after reset
        plan_checked(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1);
        plan_vertex(C_MIN, C_MAX, C_MIN, 1'b0);
        plan_checked(C_MAX, C_MIN, C_MAX, 1'b1, 1'b1);
        // zero normal: every turn is zero, so convex
        plan_vertex('0, '0, '0, 1'b0);
        plan_vertex(C_ONE, '0, '0, 1'b0);
        plan_checked('0, C_ONE, '0, 1'b1, 1'b0);
        // counter-clockwise then clockwise triangle about +z
        plan_write(polycv_pkg::CFG_NORMAL_Z, C_ONE);
        plan_vertex('0, '0, '0, 1'b0);
        plan_vertex(C_ONE, '0, '0, 1'b0);
        plan_vertex('0, C_ONE, '0, 1'b1);
        plan_vertex('0, '0, '0, 1'b0);
        plan_vertex('0, C_ONE, '0, 1'b0);
        plan_vertex(C_ONE, '0, '0, 1'b1);
        // repeated vertex collapses every turn to zero
        plan_vertex(32'sd5, 32'sd5, 32'sd5, 1'b0);
        plan_vertex(32'sd5, 32'sd5, 32'sd5, 1'b0);
        plan_checked(32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b0);
        // extreme normal and extreme coordinates
        plan_write(polycv_pkg::CFG_NORMAL_X, C_MIN);
        plan_write(polycv_pkg::CFG_NORMAL_Y, C_MAX);
        plan_write(polycv_pkg::CFG_NORMAL_Z, C_MIN);
        plan_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        plan_vertex(C_MAX, C_MIN, C_MAX, 1'b0);
        plan_vertex(C_MAX, C_MAX, C_MIN, 1'b0);
        plan_vertex(C_MIN, C_MAX, C_MAX, 1'b1);
        plan_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
        plan_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        plan_vertex(C_MAX, C_MIN, C_MAX, 1'b1);
    endtask

    // Offer one vertex beat, predict on acceptance
    task automatic send_vertex(input vertex_t v, input bit last, input bit typed,
                               input verdict_t typed_verdict);
        verdict_t predicted;
        bit       emits;
        // idle cycles drawn one cycle at a time
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v.z, v.y, v.x};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        vertices_sent++;
        emits = advance_convexity(v, last, predicted);
        if (emits)
        begin
            pending_verdicts.insert(pending_verdicts.size(),
                                    typed ? typed_verdict : predicted);
            polygons_sent++;
        end
    endtask

    task automatic send_outline();
        foreach (outline[i])
            send_vertex(outline[i], i == outline.size() - 1, 1'b0, '0);
    endtask

    // Stop offering and wait until every verdict is back and the sign unit is quiet
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [polycv_pkg::CFG_INDEX_W-1:0] idx,
                                  input coord_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            polycv_pkg::CFG_NORMAL_X: normal_x = val;
            polycv_pkg::CFG_NORMAL_Y: normal_y = val;
            polycv_pkg::CFG_NORMAL_Z: normal_z = val;
            default: ;
        endcase
        normal_writes++;
        @(posedge clk);
    endtask

    function automatic coord_t random_magnitude();
        coord_t m;
        case ($urandom_range(0, 9))
            0:       m = '0;
            1:       m = C_MAX;
            2:       m = C_MIN;
            default:
            begin
                m = coord_t'($urandom_range(1, 1 << $urandom_range(0, 30)));
                if ($urandom_range(0, 1) == 1)
                    m = -m;
            end
        endcase
        return m;
    endfunction

    function automatic coord_t random_tilt();
        if ($urandom_range(0, 3) != 0)
            return '0;
        return coord_t'($urandom_range(0, 1 << 17)) - C_ONE;
    endfunction

    // New normal for a chunk: mostly along one axis, sometimes fully random
    task automatic program_normal(input bit noisy);
        coord_t n[3];
        plane_axis = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++)
            n[a] = noisy ? coord_t'($urandom) : random_tilt();
        if (!noisy)
            n[plane_axis] = random_magnitude();
        write_register(polycv_pkg::CFG_NORMAL_X, n[0]);
        write_register(polycv_pkg::CFG_NORMAL_Y, n[1]);
        write_register(polycv_pkg::CFG_NORMAL_Z, n[2]);
    endtask

    // Convex outline: ordered subset of the ring, scaled, shifted, maybe reversed
    task automatic make_ring_outline();
        int chosen[$];
        int k, picked, rot, s, ou, ov, w, p;
        bit flip;
        outline.delete();
        k = $urandom_range(3, 8);
        picked = 0;
        for (int i = 0; i < 12; i++)
        begin
            if ($urandom_range(0, 11 - i) < k - picked)
            begin
                chosen.insert(chosen.size(), i);
                picked++;
            end
        end
        rot  = $urandom_range(0, k - 1);
        flip = ($urandom_range(0, 9) < 3);
        s    = $urandom_range(1, 1 << $urandom_range(0, 26));
        ou   = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        ov   = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        w    = int'($urandom);
        for (int j = 0; j < k; j++)
        begin
            p = flip ? chosen[(rot + k - j) % k] : chosen[(rot + j) % k];
            outline.insert(outline.size(),
                           on_plane(ou + s * ring_u[p], ov + s * ring_v[p], w));
            // occasional repeated vertex
            if ($urandom_range(0, 19) == 0)
                outline.insert(outline.size(), outline[outline.size() - 1]);
        end
    endtask

    // Random junk, including short polygons and repeats
    task automatic make_noise_outline(input int count);
        outline.delete();
        for (int j = 0; j < count; j++)
        begin
            if (j > 0 && $urandom_range(0, 4) == 0)
                outline.insert(outline.size(), outline[j - 1]);
            else
                outline.insert(outline.size(), random_vertex());
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit do_hold);
        int start, chunk_start, chunk, pick;
        bit noisy;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = vertices_sent;
        chunk = 0;
        while (vertices_sent - start < PHASE_ITEMS)
        begin
            wait_until_idle();
            noisy = ($urandom_range(0, 4) == 0);
            program_normal(noisy);
            if (do_hold && chunk == 1)
                hold_requested++;
            chunk_start = vertices_sent;
            while (vertices_sent - chunk_start < CHUNK_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    make_noise_outline($urandom_range(1, 2));
                else if (pick < 30 || noisy)
                    make_noise_outline($urandom_range(1, 6));
                else
                    make_ring_outline();
                send_outline();
            end
            chunk++;
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requested)
        begin
            hold_served = hold_requested;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Verdict checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_verdict.is_convex = m_tdata[0];
            got_verdict.too_few   = m_tdata[1];
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result beat: is_convex=%0b too_few_vertices=%0b",
                       got_verdict.is_convex, got_verdict.too_few);
                mismatches++;
            end
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                verdicts_checked++;
                if (got_verdict.is_convex !== want_verdict.is_convex)
                begin
                    $error("is_convex: expected %0b, got %0b",
                           want_verdict.is_convex, got_verdict.is_convex);
                    mismatches++;
                end
                if (got_verdict.too_few !== want_verdict.too_few)
                begin
                    $error("too_few_vertices: expected %0b, got %0b",
                           want_verdict.too_few, got_verdict.too_few);
                    mismatches++;
                end
                if (want_verdict.is_convex)
                    convex_seen++;
                if (want_verdict.too_few)
                    short_seen++;
            end
        end
    end

    // Watchdog: too long without any beat or register write
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_polygon_convexity_check NOT OK");
        $finish;
    end

    // Stimulus
    initial
    begin
        build_directed_plan();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == PLAN_WRITE)
            begin
                wait_until_idle();
                write_register(directed_plan[i].reg_index, directed_plan[i].value);
            end
            else
            begin
                send_vertex(directed_plan[i].vtx, directed_plan[i].last,
                            directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random: sender idles 32%, receiver 62%; then swapped; then no idling
        // with a long receiver hold-off
        run_phase(32, 62, 1'b0);
        run_phase(62, 32, 1'b0);
        run_phase(0, 0, 1'b1);

        wait_until_idle();
        $display("Sent %0d vertices in %0d polygons with %0d normal writes.",
                 vertices_sent, polygons_sent, normal_writes);
        $display("Checked %0d verdicts: %0d convex, %0d too short, %0d mismatches.",
                 verdicts_checked, convex_seen, short_seen, mismatches);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb_polygon_convexity_check OK");
        else
            $display("tb_polygon_convexity_check NOT OK");
        $finish;
    end

endmodule
